// File: src/cob_pkg.sv
// Shared types, constants and helpers for the cursor overlay blend block.
// Used by every module under src; depends on nothing else.
`default_nettype none

package cob_pkg;

   // Cursor image store geometry. The word count must be a power of two.
   localparam int CURSOR_WORDS = 4096;
   localparam int STORE_AW     = $clog2(CURSOR_WORDS);

   // Fixed field widths of the pixel beat and of the registers.
   localparam int POS_W     = 13;
   localparam int FRAME_W   = 14;
   localparam int WADDR_W   = 12;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DW    = 14;

   // Result queue that decouples the pipeline from the response side.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = QUEUE_PTR_W + 1;

   localparam logic [31:0] ALPHA_MASK = 32'hFF00_0000;
   localparam logic [31:0] COLOR_MASK = 32'h00FF_FFFF;
   localparam logic [31:0] ALL_ONES   = 32'hFFFF_FFFF;

   typedef enum logic [1:0] {
      CT_HIDDEN = 2'd0,
      CT_COLOR  = 2'd1,
      CT_MONO   = 2'd2,
      CT_MASKED = 2'd3
   } cursor_type_type;

   typedef enum logic {
      OP_LOAD  = 1'b0,
      OP_PIXEL = 1'b1
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CURSOR_TYPE   = 3'd0,
      CSR_CURSOR_LEFT   = 3'd1,
      CSR_CURSOR_TOP    = 3'd2,
      CSR_CURSOR_WIDTH  = 3'd3,
      CSR_CURSOR_HEIGHT = 3'd4,
      CSR_CURSOR_PITCH  = 3'd5,
      CSR_FRAME_WIDTH   = 3'd6,
      CSR_FRAME_HEIGHT  = 3'd7
   } csr_index_type;

   typedef struct packed {
      cursor_type_type    ctype;
      logic [POS_W-1:0]   left;
      logic [POS_W-1:0]   top;
      logic [6:0]         width;
      logic [7:0]         height;
      logic [8:0]         pitch;
      logic [FRAME_W-1:0] fwidth;
      logic [FRAME_W-1:0] fheight;
   } cfg_type;

   // Per-pixel control that travels alongside the store read.
   typedef struct packed {
      logic            valid;
      logic            hit;
      cursor_type_type ctype;
      logic [2:0]      bit_sel;
      logic [1:0]      byte_a;
      logic [1:0]      byte_b;
      logic [31:0]     pixel;
   } lookup_type;

   typedef struct packed {
      logic        hit;
      logic [31:0] pixel;
   } result_type;

   function automatic logic [7:0] pick_byte(input logic [31:0] word, input logic [1:0] sel);
      logic [7:0] b;
      case (sel)
         2'd0:    b = word[7:0];
         2'd1:    b = word[15:8];
         2'd2:    b = word[23:16];
         default: b = word[31:24];
      endcase
      return b;
   endfunction

endpackage

`default_nettype wire

// File: src/cob_store.sv
// Cursor image store: one write port and two registered read ports.
// Depends on cob_pkg for the store geometry.
`default_nettype none

module cob_store
   import cob_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                wr_en,
   input  wire logic [STORE_AW-1:0] wr_addr,
   input  wire logic [31:0]         wr_data,
   input  wire logic                rd_en,
   input  wire logic [STORE_AW-1:0] rd_addr_a,
   input  wire logic [STORE_AW-1:0] rd_addr_b,
   output logic      [31:0]         rd_data_a,
   output logic      [31:0]         rd_data_b
);

   logic [31:0] mem [CURSOR_WORDS];
   logic [31:0] rd_a_ff;
   logic [31:0] rd_b_ff;

   // A read at the same edge as a write to that entry returns the old word,
   // which is what a later load must not disturb.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= mem[rd_addr_a];
         rd_b_ff <= mem[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

`default_nettype wire

// File: src/cob_locate.sv
// Clipping, hit test and store address generation for pixel beats.
// Depends on cob_pkg; drives the read ports of cob_store.
`default_nettype none

module cob_locate
   import cob_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire cfg_type             cfg,
   input  wire logic                pix_go,
   input  wire logic [POS_W-1:0]    pixel_x,
   input  wire logic [POS_W-1:0]    pixel_y,
   input  wire logic [31:0]         screen_pixel,
   output logic                     rd_en,
   output logic      [STORE_AW-1:0] rd_addr_a,
   output logic      [STORE_AW-1:0] rd_addr_b,
   output lookup_type               lk
);

   logic               left_in_frame;
   logic               top_in_frame;
   logic [FRAME_W-1:0] room_w;
   logic [FRAME_W-1:0] room_h;
   logic [7:0]         img_h;
   logic [6:0]         vis_w;
   logic [7:0]         vis_h;
   logic [FRAME_W-1:0] dx;
   logic [FRAME_W-1:0] dy;
   logic               hit_x;
   logic               hit_y;
   logic               hit;

   logic               s1_valid_ff, s1_valid_in;
   logic               s1_hit_ff;
   cursor_type_type    s1_type_ff;
   logic [6:0]         s1_col_ff;
   logic [7:0]         s1_row_ff;
   logic [31:0]        s1_pixel_ff;

   logic               mono;
   logic [8:0]         stride;
   logic [16:0]        prod_a;
   logic [6:0]         col_term;
   logic [17:0]        sum_a;
   logic [15:0]        word_a;
   logic [8:0]         row_b;
   logic [17:0]        prod_b;
   logic [17:0]        sum_b;
   logic [15:0]        word_b;

   // Visible rectangle after clipping to the frame.
   always_comb begin
      img_h         = (cfg.ctype == CT_MONO) ? {1'b0, cfg.height[7:1]} : cfg.height;
      left_in_frame = {1'b0, cfg.left} < cfg.fwidth;
      top_in_frame  = {1'b0, cfg.top} < cfg.fheight;
      room_w        = cfg.fwidth - {1'b0, cfg.left};
      room_h        = cfg.fheight - {1'b0, cfg.top};
      if (!left_in_frame) begin
         vis_w = '0;
      end else if ({7'd0, cfg.width} < room_w) begin
         vis_w = cfg.width;
      end else begin
         vis_w = room_w[6:0];
      end
      if (!top_in_frame) begin
         vis_h = '0;
      end else if ({6'd0, img_h} < room_h) begin
         vis_h = img_h;
      end else begin
         vis_h = room_h[7:0];
      end
      dx    = {1'b0, pixel_x} - {1'b0, cfg.left};
      dy    = {1'b0, pixel_y} - {1'b0, cfg.top};
      hit_x = (pixel_x >= cfg.left) && (dx < {7'd0, vis_w});
      hit_y = (pixel_y >= cfg.top) && (dy < {6'd0, vis_h});
      hit   = (cfg.ctype != CT_HIDDEN) && hit_x && hit_y;
   end

   assign s1_valid_in = pix_go;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pix_go) begin
         s1_hit_ff   <= hit;
         s1_type_ff  <= cfg.ctype;
         s1_col_ff   <= dx[6:0];
         s1_row_ff   <= dy[7:0];
         s1_pixel_ff <= screen_pixel;
      end
   end

   // Port A serves the color word or the AND plane byte, port B the XOR plane.
   always_comb begin
      mono     = (s1_type_ff == CT_MONO);
      stride   = mono ? cfg.pitch : {2'b00, cfg.pitch[8:2]};
      prod_a   = {9'd0, s1_row_ff} * {8'd0, stride};
      col_term = mono ? {3'b000, s1_col_ff[6:3]} : s1_col_ff;
      sum_a    = {1'b0, prod_a} + {11'd0, col_term};
      word_a   = mono ? sum_a[17:2] : sum_a[15:0];
      row_b    = {1'b0, s1_row_ff} + {1'b0, img_h};
      prod_b   = {9'd0, row_b} * {9'd0, cfg.pitch};
      sum_b    = prod_b + {14'd0, s1_col_ff[6:3]};
      word_b   = sum_b[17:2];
   end

   assign rd_en     = s1_valid_ff;
   assign rd_addr_a = word_a[STORE_AW-1:0];
   assign rd_addr_b = word_b[STORE_AW-1:0];

   always_comb begin
      lk.valid   = s1_valid_ff;
      lk.hit     = s1_hit_ff;
      lk.ctype   = s1_type_ff;
      lk.bit_sel = s1_col_ff[2:0];
      lk.byte_a  = sum_a[1:0];
      lk.byte_b  = sum_b[1:0];
      lk.pixel   = s1_pixel_ff;
   end

   a_hit_needs_cursor: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_hit_ff) |-> (s1_type_ff != CT_HIDDEN))
      else $error("hit recorded while the cursor is hidden");

endmodule

`default_nettype wire

// File: src/cob_blend.sv
// Combines the screen pixel with the cursor store words read for it.
// Depends on cob_pkg; takes its control from cob_locate and data from cob_store.
`default_nettype none

module cob_blend
   import cob_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire lookup_type lk,
   input  wire logic [31:0] rd_data_a,
   input  wire logic [31:0] rd_data_b,
   output logic            res_valid,
   output result_type      res
);

   lookup_type  s2_ff, s2_in;
   logic [7:0]  and_byte;
   logic [7:0]  xor_byte;
   logic        and_bit;
   logic        xor_bit;
   logic [31:0] blended;

   assign s2_in = lk;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ff.valid <= 1'b0;
      end else begin
         s2_ff.valid <= s2_in.valid;
      end
      s2_ff.hit     <= s2_in.hit;
      s2_ff.ctype   <= s2_in.ctype;
      s2_ff.bit_sel <= s2_in.bit_sel;
      s2_ff.byte_a  <= s2_in.byte_a;
      s2_ff.byte_b  <= s2_in.byte_b;
      s2_ff.pixel   <= s2_in.pixel;
   end

   always_comb begin
      // Mask bits run from the most significant bit of each byte.
      and_byte = pick_byte(rd_data_a, s2_ff.byte_a);
      xor_byte = pick_byte(rd_data_b, s2_ff.byte_b);
      and_bit  = and_byte[~s2_ff.bit_sel];
      xor_bit  = xor_byte[~s2_ff.bit_sel];
      blended  = s2_ff.pixel;
      if (s2_ff.hit) begin
         case (s2_ff.ctype)
            CT_COLOR: begin
               if (rd_data_a != '0) begin
                  blended = rd_data_a;
               end
            end
            CT_MONO: begin
               blended = (s2_ff.pixel & (and_bit ? ALL_ONES : ALPHA_MASK))
                       ^ (xor_bit ? COLOR_MASK : '0);
            end
            CT_MASKED: begin
               if ((rd_data_a & ALPHA_MASK) != '0) begin
                  blended = (s2_ff.pixel ^ rd_data_a) | ALPHA_MASK;
               end else begin
                  blended = rd_data_a | ALPHA_MASK;
               end
            end
            default: begin
               blended = s2_ff.pixel;
            end
         endcase
      end
   end

   assign res_valid = s2_ff.valid;
   assign res.hit   = s2_ff.hit;
   assign res.pixel = blended;

   a_follows_lookup: assert property (@(posedge clock) disable iff (reset)
      s2_ff.valid |-> $past(lk.valid))
      else $error("blend stage holds a beat that never left the lookup stage");

endmodule

`default_nettype wire

// File: src/cob_rsp_queue.sv
// Small result queue between the blend stage and the response channel.
// Depends on cob_pkg for the result type and queue depth.
`default_nettype none

module cob_rsp_queue
   import cob_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire result_type             push_data,
   input  wire logic                   pop,
   output logic                        not_empty,
   output result_type                  head,
   output logic      [QUEUE_CNT_W-1:0] count
);

   result_type             entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign not_empty = (count_ff != '0);
   assign head      = entry_ff[rd_ptr_ff];
   assign count     = count_ff;

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH)) |-> !push)
      else $error("result pushed into a full queue");

endmodule

`default_nettype wire

// File: src/cursor_overlay_blend.sv
// Pixel beats pass the lookup stage, the store read, then the result queue; loads
// write the store at the accept edge. One beat of either kind is taken every cycle
// while req_stall is low; the four-entry result queue keeps intake going while a
// result waits; intake pauses when queued and in-flight pixel beats fill it.
// Reset clears the registers, the pipeline and the queue; the cursor store is
// not cleared and holds unknown words until loaded.
`default_nettype none

module cursor_overlay_blend
   import cob_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic                 req_op,
   input  wire logic [WADDR_W-1:0]   req_word_address,
   input  wire logic [31:0]          req_word_data,
   input  wire logic [POS_W-1:0]     req_pixel_x,
   input  wire logic [POS_W-1:0]     req_pixel_y,
   input  wire logic [31:0]          req_screen_pixel,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic      [31:0]          rsp_pixel_out,
   output logic                      rsp_cursor_hit,
   input  wire logic                 csr_write,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_DW-1:0]    csr_data
);

   cfg_type                cfg_ff, cfg_in;
   logic                   req_go;
   logic                   load_go;
   logic                   pix_go;
   logic [15:0]            wr_addr_ext;
   logic                   rd_en;
   logic [STORE_AW-1:0]    rd_addr_a;
   logic [STORE_AW-1:0]    rd_addr_b;
   logic [31:0]            rd_data_a;
   logic [31:0]            rd_data_b;
   lookup_type             lk;
   logic                   res_valid;
   result_type             res;
   logic                   rsp_go;
   result_type             head;
   logic [QUEUE_CNT_W-1:0] q_count;
   logic [QUEUE_CNT_W-1:0] in_flight;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_CURSOR_TYPE:   cfg_in.ctype   = cursor_type_type'(csr_data[1:0]);
            CSR_CURSOR_LEFT:   cfg_in.left    = csr_data[POS_W-1:0];
            CSR_CURSOR_TOP:    cfg_in.top     = csr_data[POS_W-1:0];
            CSR_CURSOR_WIDTH:  cfg_in.width   = csr_data[6:0];
            CSR_CURSOR_HEIGHT: cfg_in.height  = csr_data[7:0];
            CSR_CURSOR_PITCH:  cfg_in.pitch   = csr_data[8:0];
            CSR_FRAME_WIDTH:   cfg_in.fwidth  = csr_data[FRAME_W-1:0];
            CSR_FRAME_HEIGHT:  cfg_in.fheight = csr_data[FRAME_W-1:0];
            default:           cfg_in         = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Every pixel in the pipeline holds a queue slot, so the queue never overflows.
   assign in_flight = q_count + QUEUE_CNT_W'(lk.valid) + QUEUE_CNT_W'(res_valid);
   assign req_stall = (in_flight >= QUEUE_CNT_W'(QUEUE_DEPTH));
   assign req_go    = req_valid && !req_stall;
   assign load_go   = req_go && (req_op == OP_LOAD);
   assign pix_go    = req_go && (req_op == OP_PIXEL);

   assign wr_addr_ext = {{(16 - WADDR_W){1'b0}}, req_word_address};

   cob_locate u_locate (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .pix_go       (pix_go),
      .pixel_x      (req_pixel_x),
      .pixel_y      (req_pixel_y),
      .screen_pixel (req_screen_pixel),
      .rd_en        (rd_en),
      .rd_addr_a    (rd_addr_a),
      .rd_addr_b    (rd_addr_b),
      .lk           (lk)
   );

   cob_store u_store (
      .clock     (clock),
      .wr_en     (load_go),
      .wr_addr   (wr_addr_ext[STORE_AW-1:0]),
      .wr_data   (req_word_data),
      .rd_en     (rd_en),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   cob_blend u_blend (
      .clock     (clock),
      .reset     (reset),
      .lk        (lk),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b),
      .res_valid (res_valid),
      .res       (res)
   );

   assign rsp_go = rsp_valid && !rsp_stall;

   cob_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_data (res),
      .pop       (rsp_go),
      .not_empty (rsp_valid),
      .head      (head),
      .count     (q_count)
   );

   assign rsp_pixel_out  = head.pixel;
   assign rsp_cursor_hit = head.hit;

   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      in_flight <= QUEUE_CNT_W'(QUEUE_DEPTH))
      else $error("more pixel beats in flight than result queue slots");

   a_load_no_result: assert property (@(posedge clock) disable iff (reset)
      load_go |=> !lk.valid)
      else $error("a store load entered the pixel pipeline");

endmodule

`default_nettype wire
